// ----- design/ostb_pkg.sv -----
`default_nettype none

package ostb_pkg;

   // Default bank size and counter width.
   localparam int NumTimersDefault  = 4;
   localparam int CountWidthDefault = 16;

   // Fixed field widths of the command and result channels.
   localparam int CmdWidth   = 2;
   localparam int IndexWidth = 2;
   localparam int LoadWidth  = 16;
   localparam int MaskWidth  = 4;

   typedef logic [CmdWidth-1:0] cmd_type;

   // Command codes.
   localparam cmd_type CMD_TICK     = 2'd0;
   localparam cmd_type CMD_START    = 2'd1;
   localparam cmd_type CMD_STOP     = 2'd2;
   localparam cmd_type CMD_STOP_ALL = 2'd3;

   // One command as it travels from the input register to the timer core.
   typedef struct packed {
      cmd_type                cmd;
      logic [IndexWidth-1:0]  timer_index;
      logic [LoadWidth-1:0]   start_count;
   } command_type;

   // One result as it leaves the timer core.
   typedef struct packed {
      logic [MaskWidth-1:0] running_mask;
      logic [MaskWidth-1:0] expired_mask;
      logic                 stop_hit;
   } result_type;

endpackage

`default_nettype wire

// ----- design/ostb_if.sv -----
`default_nettype none

// Command channel.
interface ostb_req_if import ostb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   cmd_type               cmd;
   logic [IndexWidth-1:0] timer_index;
   logic [LoadWidth-1:0]  start_count;

   modport source (output valid, cmd, timer_index, start_count, input ready);
   modport sink (input valid, cmd, timer_index, start_count, output ready);
endinterface

// Result channel.
interface ostb_rsp_if import ostb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MaskWidth-1:0] running_mask;
   logic [MaskWidth-1:0] expired_mask;
   logic                 stop_hit;

   modport source (output valid, running_mask, expired_mask, stop_hit, input ready);
   modport sink (input valid, running_mask, expired_mask, stop_hit, output ready);
endinterface

`default_nettype wire

// ----- design/ostb_timer_core.sv -----
`default_nettype none

module ostb_timer_core import ostb_pkg::*; #(
   parameter int NUM_TIMERS  = NumTimersDefault,
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        exec,
   input  wire command_type command,
   output result_type       result
);

   // Only the first four timers show up in the result masks.
   localparam int VisibleTimers = (NUM_TIMERS < MaskWidth) ? NUM_TIMERS : MaskWidth;

   logic [NUM_TIMERS-1:0]  running_ff;
   logic [NUM_TIMERS-1:0]  running_in;
   logic [NUM_TIMERS-1:0]  pending_ff;
   logic [NUM_TIMERS-1:0]  pending_in;
   logic [COUNT_WIDTH-1:0] ticks_ff [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] ticks_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  selected;
   logic [NUM_TIMERS-1:0]  hit_vec;
   logic [COUNT_WIDTH-1:0] load_value;

   assign load_value = COUNT_WIDTH'(command.start_count);

   // Next state of every timer for the command in the input register.
   always_comb begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
         selected[t]   = (32'(command.timer_index) == 32'(t));
         hit_vec[t]    = 1'b0;
         running_in[t] = running_ff[t];
         pending_in[t] = pending_ff[t];
         ticks_in[t]   = ticks_ff[t];
         case (command.cmd)
            CMD_TICK: begin
               if (running_ff[t]) begin
                  ticks_in[t] = ticks_ff[t] - COUNT_WIDTH'(1);
                  if (ticks_ff[t] == COUNT_WIDTH'(1)) begin
                     pending_in[t] = 1'b1;
                     running_in[t] = 1'b0;
                  end
               end
            end
            CMD_START: begin
               if (selected[t]) begin
                  pending_in[t] = 1'b0;
                  ticks_in[t]   = load_value;
                  running_in[t] = 1'b1;
               end
            end
            CMD_STOP: begin
               if (selected[t] && (running_ff[t] || pending_ff[t])) begin
                  hit_vec[t]    = 1'b1;
                  running_in[t] = 1'b0;
                  pending_in[t] = 1'b0;
                  ticks_in[t]   = '0;
               end
            end
            default: begin
               running_in[t] = 1'b0;
               pending_in[t] = 1'b0;
               ticks_in[t]   = '0;
            end
         endcase
      end
   end

   // Result masks reflect the state after the command.
   always_comb begin
      result.running_mask = '0;
      result.expired_mask = '0;
      for (int t = 0; t < VisibleTimers; t++) begin
         result.running_mask[t] = running_in[t];
         result.expired_mask[t] = pending_in[t];
      end
      result.stop_hit = |hit_vec;
   end

   // Timer state advances once per executed command.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         pending_ff <= '0;
         for (int t = 0; t < NUM_TIMERS; t++) begin
            ticks_ff[t] <= '0;
         end
      end else if (exec) begin
         running_ff <= running_in;
         pending_ff <= pending_in;
         for (int t = 0; t < NUM_TIMERS; t++) begin
            ticks_ff[t] <= ticks_in[t];
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/one_shot_timer_bank.sv -----
// Bank of one-shot countdown timers driven by one command per transfer on
// req_chan (tick, start, stop, stop all); every command returns one result on
// rsp_chan with the running and expired masks after the command and, for a
// stop, whether the timer was live. A command waits in the input register
// until the result register is free or being emptied. In that cycle the
// timer state is updated and the result is captured in the result register.
// One command is accepted every cycle while results are taken. When
// rsp_chan.ready is low and both registers hold an item, req_chan.ready
// drops in that same cycle and stays low until the result leaves.
`default_nettype none

module one_shot_timer_bank import ostb_pkg::*; #(
   parameter int NUM_TIMERS  = NumTimersDefault,
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input wire logic clock,
   input wire logic reset,
   ostb_req_if.sink   req_chan,
   ostb_rsp_if.source rsp_chan
);

   logic        cmd_valid_ff;
   logic        cmd_valid_in;
   command_type cmd_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_ff;
   result_type  core_result;
   logic        exec;
   logic        req_take;

   // The command executes when the result register is free or being emptied.
   assign exec     = cmd_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !cmd_valid_ff || exec;

   assign cmd_valid_in = req_take || (cmd_valid_ff && !exec);
   assign rsp_valid_in = exec || (rsp_valid_ff && !rsp_chan.ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff.cmd         <= req_chan.cmd;
         cmd_ff.timer_index <= req_chan.timer_index;
         cmd_ff.start_count <= req_chan.start_count;
      end
   end

   ostb_timer_core #(
      .NUM_TIMERS (NUM_TIMERS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .exec   (exec),
      .command(cmd_ff),
      .result (core_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.running_mask = rsp_ff.running_mask;
   assign rsp_chan.expired_mask = rsp_ff.expired_mask;
   assign rsp_chan.stop_hit     = rsp_ff.stop_hit;

endmodule

`default_nettype wire

// ----- design/ostb_checker.sv -----
`default_nettype none

module ostb_checker import ostb_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [MaskWidth-1:0] rsp_running_mask,
   input wire logic [MaskWidth-1:0] rsp_expired_mask,
   input wire logic                 rsp_stop_hit
);

   // A timer is never counting and expired at the same time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_running_mask & rsp_expired_mask) == '0))
      else $error("timer shown both running and expired");

   // A successful stop leaves at least that timer idle, so the masks cannot be full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stop_hit) |->
         ((rsp_running_mask | rsp_expired_mask) != {MaskWidth{1'b1}}))
      else $error("stop hit reported with inconsistent masks");

   // No result can appear in the first cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A command taken into an empty pipeline cannot produce a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && req_valid && req_ready && !$past(req_valid && req_ready)) |=>
         (!rsp_valid || $past(rsp_valid)))
      else $error("result appeared before the command was executed");

   // A stalled result holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_running_mask) && $stable(rsp_expired_mask) &&
          $stable(rsp_stop_hit)))
      else $error("stalled result changed");

endmodule

bind one_shot_timer_bank ostb_checker u_ostb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_running_mask(rsp_chan.running_mask),
   .rsp_expired_mask(rsp_chan.expired_mask),
   .rsp_stop_hit    (rsp_chan.stop_hit)
);

`default_nettype wire
